>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define APF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define APF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/apf_pkg.sv
// ----------------------------------------------------------------------------
// apf_pkg
// Types and constants shared by the aging packet FIFO modules.
// ----------------------------------------------------------------------------
package apf_pkg;

   localparam int OP_W   = 3;
   localparam int ID_W   = 16;
   localparam int HDR_W  = 32;
   localparam int TIME_W = 32;
   localparam int OCC_W  = 6;
   localparam int DROP_W = 32;
   localparam int CSR_W  = 32;
   localparam int ADDR_W = 3;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
   localparam logic [OP_W-1:0] OP_FLUSH   = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE  = 3'd4;
   localparam logic [OP_W-1:0] OP_STATUS  = 3'd5;

   localparam logic KIND_RESP = 1'b0;
   localparam logic KIND_DROP = 1'b1;

   localparam logic REG_MAX_SIZE  = 1'b0;
   localparam logic REG_MAX_DELAY = 1'b1;

   localparam logic [OCC_W-1:0]  MAX_SIZE_RST  = 6'd63;
   localparam logic [TIME_W-1:0] MAX_DELAY_RST = 32'd500000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_OP,
      ST_HEAD
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [HDR_W-1:0]  hdr;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   // Status seen by the sequencer.
   typedef struct packed {
      logic            accept;
      logic [OP_W-1:0] new_op;
      logic [OP_W-1:0] op;
      logic            scan_done;
      logic            has_entry;
   } stat_type;

   // Phase strobes from the sequencer to the datapath.
   typedef struct packed {
      logic scan_init;
      logic scan;
      logic op_cycle;
      logic head_cycle;
      logic busy;
   } ctrl_type;

endpackage

>>> src/aging_packet_fifo.sv
// ----------------------------------------------------------------------------
// aging_packet_fifo
// Bounded FIFO of packet descriptors with lifetime expiry, held in one RAM.
// ----------------------------------------------------------------------------
// An item runs from the start transfer through the compaction scan (enqueue,
// dequeue, peek and remove only), the operation step and, for a dequeue or peek
// that finds an entry, the head read; flush, status and undefined codes skip the
// scan. The scan reads one entry per cycle through the single read port. Drop
// notices stream one per cycle; the receiver cannot stall results, and a new
// item can start on the edge that ends the final result. Reset empties the queue.

`include "assert_macros.svh"

module aging_packet_fifo #(
   parameter int DEPTH = 63
) (
   input  logic                            clock,
   input  logic                            reset,
   // Command channel
   input  logic                            start,
   output logic                            busy,
   input  logic [apf_pkg::OP_W-1:0]        req_op,
   input  logic [apf_pkg::ID_W-1:0]        req_packet_id,
   input  logic [apf_pkg::HDR_W-1:0]       req_header_ref,
   input  logic [apf_pkg::TIME_W-1:0]      req_now_time,
   // Result channel
   output logic                            rsp_valid,
   output logic                            rsp_kind,
   output logic                            rsp_ok,
   output logic [apf_pkg::ID_W-1:0]        rsp_out_packet_id,
   output logic [apf_pkg::HDR_W-1:0]       rsp_out_header_ref,
   output logic [apf_pkg::OCC_W-1:0]       rsp_occupancy,
   output logic [apf_pkg::DROP_W-1:0]      rsp_dropped_total,
   output logic                            rsp_last,
   // Configuration port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [apf_pkg::ADDR_W-1:0]      paddr,
   input  logic [apf_pkg::CSR_W-1:0]       pwdata,
   output logic [apf_pkg::CSR_W-1:0]       prdata,
   output logic                            pready
);

   import apf_pkg::*;

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = $clog2(2 * DEPTH);
   localparam int ENTRY_W = $bits(entry_type);

   // Configuration registers.
   logic [OCC_W-1:0]  max_size_ff;
   logic [TIME_W-1:0] max_delay_ff;
   logic              csr_write;

   // Queue state. The entries live in the RAM; head, count and the drop
   // counter are flops.
   logic [IDX_W-1:0]  head_ff,  head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DROP_W-1:0] drop_ff,  drop_in;

   // Latched command.
   logic [OP_W-1:0]   op_ff,  op_in;
   logic [ID_W-1:0]   pid_ff, pid_in;
   logic [HDR_W-1:0]  hdr_ff, hdr_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // Compaction scan: rd_cnt walks the logical positions being read, wr_cnt
   // is where the next surviving entry is written back. pend marks a read
   // whose data arrives in the current cycle.
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0]  wr_cnt_ff, wr_cnt_in;
   logic [CNT_W-1:0]  len_ff,    len_in;
   logic              pend_ff,   pend_in;
   logic              found_ff,  found_in;
   logic [ID_W-1:0]   fid_ff,    fid_in;
   logic [HDR_W-1:0]  fhdr_ff,   fhdr_in;

   // Result output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff,  rsp_kind_in;
   logic              rsp_ok_ff,    rsp_ok_in;
   logic [ID_W-1:0]   rsp_id_ff,    rsp_id_in;
   logic [HDR_W-1:0]  rsp_hdr_ff,   rsp_hdr_in;
   logic [OCC_W-1:0]  rsp_occ_ff,   rsp_occ_in;
   logic [DROP_W-1:0] rsp_drop_ff,  rsp_drop_in;
   logic              rsp_last_ff,  rsp_last_in;

   // RAM ports.
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   entry_type         ram_wdata;
   logic              ram_re;
   logic [IDX_W-1:0]  ram_raddr;
   entry_type         ram_rdata;
   logic [ENTRY_W-1:0] ram_rbits;

   // Sequencer link.
   stat_type          stat;
   ctrl_type          ctrl;
   logic              accept;

   // Scan decisions.
   logic [TIME_W-1:0] age;
   logic              expired;
   logic              id_hit;
   logic              hit;
   logic [OCC_W-1:0]  cap;

   // Physical slot of logical position k: one compare and subtract, since
   // both head and k stay below DEPTH.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] k);
      logic [SUM_W-1:0] sum;
      begin
         sum = SUM_W'(head) + SUM_W'(k);
         if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
         end
         return sum[IDX_W-1:0];
      end
   endfunction

   // ------------------------------------------------------------------
   // Configuration port. Writes complete in the access phase; pready is
   // tied high, so no access is ever held in a wait state.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff  <= MAX_SIZE_RST;
         max_delay_ff <= MAX_DELAY_RST;
      end else if (csr_write) begin
         case (paddr[2])
            REG_MAX_SIZE:  max_size_ff  <= pwdata[OCC_W-1:0];
            REG_MAX_DELAY: max_delay_ff <= pwdata[TIME_W-1:0];
            default: begin
               max_size_ff <= max_size_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_MAX_SIZE:  prdata = CSR_W'(max_size_ff);
         REG_MAX_DELAY: prdata = CSR_W'(max_delay_ff);
         default:       prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   assign accept = start && !ctrl.busy;
   assign busy   = ctrl.busy;

   always_comb begin
      stat.accept    = accept;
      stat.new_op    = req_op;
      stat.op        = op_ff;
      stat.scan_done = !pend_ff && (rd_cnt_ff == len_ff);
      stat.has_entry = (count_ff != '0);
   end

   apf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // ------------------------------------------------------------------
   // Entry memory
   // ------------------------------------------------------------------
   apf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rbits)
   );

   assign ram_rdata = entry_type'(ram_rbits);

   // The sweep drops an entry whose modular age has reached the lifetime;
   // remove drops only the first entry whose id matches.
   assign age     = now_ff - ram_rdata.stamp;
   assign expired = (age >= max_delay_ff);
   assign id_hit  = (ram_rdata.id == pid_ff) && !found_ff;
   assign hit     = (op_ff == OP_REMOVE) ? id_hit : expired;
   assign cap     = (max_size_ff > OCC_W'(DEPTH)) ? OCC_W'(DEPTH) : max_size_ff;

   // ------------------------------------------------------------------
   // Datapath next state
   // ------------------------------------------------------------------
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      drop_in   = drop_ff;
      op_in     = op_ff;
      pid_in    = pid_ff;
      hdr_in    = hdr_ff;
      now_in    = now_ff;
      rd_cnt_in = rd_cnt_ff;
      wr_cnt_in = wr_cnt_ff;
      len_in    = len_ff;
      pend_in   = pend_ff;
      found_in  = found_ff;
      fid_in    = fid_ff;
      fhdr_in   = fhdr_ff;

      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_RESP;
      rsp_ok_in    = 1'b0;
      rsp_id_in    = '0;
      rsp_hdr_in   = '0;
      rsp_occ_in   = rsp_occ_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_last_in  = 1'b0;

      ram_we    = 1'b0;
      ram_waddr = slot_of(head_ff, wr_cnt_ff);
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = head_ff;

      // A start transfer captures the command and arms the scan over the
      // entries held right now.
      if (ctrl.scan_init) begin
         op_in     = req_op;
         pid_in    = req_packet_id;
         hdr_in    = req_header_ref;
         now_in    = req_now_time;
         rd_cnt_in = '0;
         wr_cnt_in = '0;
         len_in    = count_ff;
         pend_in   = 1'b0;
         found_in  = 1'b0;
      end

      // Compaction: one read issued and one returned entry judged per cycle.
      // Survivors are written back at wr_cnt, which never passes rd_cnt, so
      // a write never lands on an entry that is still to be read.
      if (ctrl.scan) begin
         if (rd_cnt_ff < len_ff) begin
            ram_re    = 1'b1;
            ram_raddr = slot_of(head_ff, rd_cnt_ff);
            rd_cnt_in = rd_cnt_ff + 1'b1;
            pend_in   = 1'b1;
         end else begin
            pend_in   = 1'b0;
         end

         if (pend_ff) begin
            if (hit) begin
               count_in = count_ff - 1'b1;
               if (op_ff == OP_REMOVE) begin
                  found_in = 1'b1;
                  fid_in   = ram_rdata.id;
                  fhdr_in  = ram_rdata.hdr;
               end else begin
                  drop_in      = drop_ff + 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_DROP;
                  rsp_ok_in    = 1'b0;
                  rsp_id_in    = ram_rdata.id;
                  rsp_hdr_in   = ram_rdata.hdr;
                  rsp_occ_in   = OCC_W'(count_in);
                  rsp_drop_in  = drop_in;
                  rsp_last_in  = 1'b0;
               end
            end else begin
               ram_we    = 1'b1;
               ram_waddr = slot_of(head_ff, wr_cnt_ff);
               ram_wdata = ram_rdata;
               wr_cnt_in = wr_cnt_ff + 1'b1;
            end
         end
      end

      // Operation step. Every branch but a dequeue or peek of a non-empty
      // queue ends the item here with its final response.
      if (ctrl.op_cycle) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         case (op_ff)
            OP_ENQUEUE: begin
               if (OCC_W'(count_ff) < cap) begin
                  ram_we          = 1'b1;
                  ram_waddr       = slot_of(head_ff, count_ff);
                  ram_wdata.id    = pid_ff;
                  ram_wdata.hdr   = hdr_ff;
                  ram_wdata.stamp = now_ff;
                  count_in        = count_ff + 1'b1;
                  rsp_ok_in       = 1'b1;
               end
            end
            OP_DEQUEUE, OP_PEEK: begin
               if (count_ff != '0) begin
                  ram_re       = 1'b1;
                  ram_raddr    = head_ff;
                  rsp_valid_in = 1'b0;
                  rsp_last_in  = 1'b0;
               end
            end
            OP_FLUSH: begin
               count_in  = '0;
               rsp_ok_in = 1'b1;
            end
            OP_REMOVE: begin
               rsp_ok_in  = found_ff;
               rsp_id_in  = found_ff ? fid_ff  : '0;
               rsp_hdr_in = found_ff ? fhdr_ff : '0;
            end
            OP_STATUS: begin
               rsp_ok_in = 1'b1;
            end
            default: begin
               rsp_ok_in = 1'b0;
            end
         endcase
         rsp_kind_in = KIND_RESP;
         rsp_occ_in  = OCC_W'(count_in);
         rsp_drop_in = drop_ff;
      end

      // Head entry has arrived from the RAM; a dequeue also retires it.
      if (ctrl.head_cycle) begin
         if (op_ff == OP_DEQUEUE) begin
            head_in  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_RESP;
         rsp_ok_in    = 1'b1;
         rsp_id_in    = ram_rdata.id;
         rsp_hdr_in   = ram_rdata.hdr;
         rsp_occ_in   = OCC_W'(count_in);
         rsp_drop_in  = drop_ff;
         rsp_last_in  = 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pid_ff      <= pid_in;
      hdr_ff      <= hdr_in;
      now_ff      <= now_in;
      rd_cnt_ff   <= rd_cnt_in;
      wr_cnt_ff   <= wr_cnt_in;
      len_ff      <= len_in;
      pend_ff     <= pend_in;
      found_ff    <= found_in;
      fid_ff      <= fid_in;
      fhdr_ff     <= fhdr_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_hdr_ff  <= rsp_hdr_in;
      rsp_occ_ff  <= rsp_occ_in;
      rsp_drop_ff <= rsp_drop_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Each result is shown for exactly one cycle, straight from the output
   // register.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_out_packet_id  = rsp_id_ff;
   assign rsp_out_header_ref = rsp_hdr_ff;
   assign rsp_occupancy      = rsp_occ_ff;
   assign rsp_dropped_total  = rsp_drop_ff;
   assign rsp_last           = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `APF_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "count above depth")
   `APF_ASSERT_IMPL(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr, "RAM clash")
   `APF_ASSERT_IMPL(a_compact_order, ctrl.scan, wr_cnt_ff <= rd_cnt_ff, "write-back ahead")
   `APF_ASSERT_IMPL(a_last_frees, rsp_valid_ff && rsp_last_ff, !busy, "last while busy")

endmodule

>>> src/apf_ram.sv
// ----------------------------------------------------------------------------
// apf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module apf_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 63
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> src/apf_ctrl.sv
// ----------------------------------------------------------------------------
// apf_ctrl
// Operation sequencer: compaction scan, operation step and head read.
// ----------------------------------------------------------------------------
module apf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  apf_pkg::stat_type stat,
   output apf_pkg::ctrl_type ctrl
);

   import apf_pkg::*;

   state_type state_ff;
   state_type state_in;

   function automatic logic needs_scan(input logic [OP_W-1:0] op);
      begin
         return (op == OP_ENQUEUE) || (op == OP_DEQUEUE) || (op == OP_PEEK) ||
                (op == OP_REMOVE);
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (stat.accept) begin
               state_in = needs_scan(stat.new_op) ? ST_SCAN : ST_OP;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_OP;
            end
         end
         ST_OP: begin
            if (((stat.op == OP_DEQUEUE) || (stat.op == OP_PEEK)) && stat.has_entry) begin
               state_in = ST_HEAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HEAD: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.scan_init = stat.accept;
         end
         ST_SCAN: begin
            ctrl.scan = 1'b1;
            ctrl.busy = 1'b1;
         end
         ST_OP: begin
            ctrl.op_cycle = 1'b1;
            ctrl.busy     = 1'b1;
         end
         ST_HEAD: begin
            ctrl.head_cycle = 1'b1;
            ctrl.busy       = 1'b1;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

>>> tb/aging_packet_fifo_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aging_packet_fifo_tb
// Self-checking bench for the aging packet FIFO. Commands are driven on the
// start/busy channel and every result strobe is compared, field by field,
// with a shadow copy of the queue kept in the bench. A short directed part
// covers the edge cases, then random traffic runs under several register
// settings and sender idle patterns.
// ----------------------------------------------------------------------------
module aging_packet_fifo_tb;
   import apf_pkg::*;

   localparam int DEPTH       = 63;
   localparam int CYCLE_LIMIT = 400000;

   // Op codes 6 and 7 are not defined by the block. They answer like status
   // but with ok low.
   localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

   // One result as the block should present it.
   typedef struct {
      logic              kind;
      logic              ok;
      logic [ID_W-1:0]   id;
      logic [HDR_W-1:0]  hdr;
      logic [OCC_W-1:0]  occ;
      logic [DROP_W-1:0] drops;
      logic              last;
   } fifo_answer_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_op;
   logic [ID_W-1:0]     req_packet_id;
   logic [HDR_W-1:0]    req_header_ref;
   logic [TIME_W-1:0]   req_now_time;
   logic                rsp_valid;
   logic                rsp_kind;
   logic                rsp_ok;
   logic [ID_W-1:0]     rsp_out_packet_id;
   logic [HDR_W-1:0]    rsp_out_header_ref;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic [DROP_W-1:0]   rsp_dropped_total;
   logic                rsp_last;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [CSR_W-1:0]    pwdata;
   logic [CSR_W-1:0]    prdata;
   logic                pready;

   // Shadow copy of the queue contents in logical order (front is the
   // oldest entry), the register settings and the drop counter.
   entry_type           shadow_entries[$];
   logic [OCC_W-1:0]    size_limit = MAX_SIZE_RST;
   logic [TIME_W-1:0]   lifetime   = MAX_DELAY_RST;
   logic [DROP_W-1:0]   shadow_drops = '0;

   // Results that accepted commands still owe, oldest first.
   fifo_answer_type     owed_answers[$];

   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count = 0;
   // Running time stamp handed to the block with each command.
   logic [TIME_W-1:0]   now_stamp = '0;

   aging_packet_fifo #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_packet_id(req_packet_id),
      .req_header_ref(req_header_ref),
      .req_now_time(req_now_time),
      .rsp_valid(rsp_valid),
      .rsp_kind(rsp_kind),
      .rsp_ok(rsp_ok),
      .rsp_out_packet_id(rsp_out_packet_id),
      .rsp_out_header_ref(rsp_out_header_ref),
      .rsp_occupancy(rsp_occupancy),
      .rsp_dropped_total(rsp_dropped_total),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs or a handshake never completes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("aging_packet_fifo_tb failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Shadow model of the queue
   // ------------------------------------------------------------------------

   // Queues one owed result. Occupancy and drop total are taken after the
   // action that the result reports.
   function automatic void owe_answer(input logic kind, input logic ok,
                                      input logic [ID_W-1:0] id,
                                      input logic [HDR_W-1:0] hdr,
                                      input logic last);
      fifo_answer_type a;
      a.kind  = kind;
      a.ok    = ok;
      a.id    = id;
      a.hdr   = hdr;
      a.occ   = OCC_W'(shadow_entries.size());
      a.drops = shadow_drops;
      a.last  = last;
      owed_answers = {owed_answers, a};
   endfunction

   // Applies one accepted command to the shadow queue and queues the drop
   // notices and the final response that it must produce.
   function automatic void apply_fifo_op(input logic [OP_W-1:0] op,
                                         input logic [ID_W-1:0] id,
                                         input logic [HDR_W-1:0] hdr,
                                         input logic [TIME_W-1:0] now);
      int                k;
      int                cap;
      logic [TIME_W-1:0] age;
      logic              ok;
      logic              found;
      logic [ID_W-1:0]   rid;
      logic [HDR_W-1:0]  rhdr;
      entry_type         fresh;
      ok    = 1'b0;
      found = 1'b0;
      rid   = '0;
      rhdr  = '0;
      k     = 0;
      // Only enqueue, dequeue and peek sweep out expired entries. The age is
      // taken modulo 2^32 so that a wrapped time stamp still ages correctly.
      if (op == OP_ENQUEUE || op == OP_DEQUEUE || op == OP_PEEK) begin
         while (k < shadow_entries.size()) begin
            age = now - shadow_entries[k].stamp;
            if (age >= lifetime) begin
               rid  = shadow_entries[k].id;
               rhdr = shadow_entries[k].hdr;
               shadow_entries.delete(k);
               shadow_drops = shadow_drops + 1'b1;
               owe_answer(KIND_DROP, 1'b0, rid, rhdr, 1'b0);
            end else begin
               k++;
            end
         end
         rid  = '0;
         rhdr = '0;
      end
      case (op)
         OP_ENQUEUE: begin
            cap = (int'(size_limit) < DEPTH) ? int'(size_limit) : DEPTH;
            if (shadow_entries.size() < cap) begin
               fresh.id    = id;
               fresh.hdr   = hdr;
               fresh.stamp = now;
               shadow_entries = {shadow_entries, fresh};
               ok = 1'b1;
            end
         end
         OP_DEQUEUE, OP_PEEK: begin
            if (shadow_entries.size() > 0) begin
               rid  = shadow_entries[0].id;
               rhdr = shadow_entries[0].hdr;
               ok   = 1'b1;
               if (op == OP_DEQUEUE)
                  shadow_entries.delete(0);
            end
         end
         OP_FLUSH: begin
            shadow_entries.delete();
            ok = 1'b1;
         end
         OP_REMOVE: begin
            // Only the first entry with a matching id goes; order is kept.
            for (int j = 0; j < shadow_entries.size() && !found; j++) begin
               if (shadow_entries[j].id == id) begin
                  rid  = shadow_entries[j].id;
                  rhdr = shadow_entries[j].hdr;
                  shadow_entries.delete(j);
                  found = 1'b1;
               end
            end
            ok = found;
         end
         OP_STATUS: ok = 1'b1;
         default:   ok = 1'b0;
      endcase
      owe_answer(KIND_RESP, ok, rid, rhdr, 1'b1);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Every result strobe is one transfer that cannot be held off, so each is
   // matched against the oldest owed result on the edge that ends it.
   always @(posedge clock) begin : result_check
      fifo_answer_type head;
      if (!reset && rsp_valid === 1'b1) begin
         if (owed_answers.size() == 0) begin
            $error("result with nothing owed: kind %0d id %h", rsp_kind,
                   rsp_out_packet_id);
            mismatch_count++;
         end else begin
            head = owed_answers[0];
            owed_answers.delete(0);
            check_field("kind", head.kind, rsp_kind);
            check_field("ok", head.ok, rsp_ok);
            check_field("out_packet_id", head.id, rsp_out_packet_id);
            check_field("out_header_ref", head.hdr, rsp_out_header_ref);
            check_field("occupancy", head.occ, rsp_occupancy);
            check_field("dropped_total", head.drops, rsp_dropped_total);
            check_field("last", head.last, rsp_last);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Presents one command and holds it until the block takes the transfer,
   // which happens on a rising edge with start high and busy low. start is
   // left high so that a following command can go out back to back.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [HDR_W-1:0] hdr,
                            input logic [TIME_W-1:0] now);
      @(negedge clock);
      start          = 1'b1;
      req_op         = op;
      req_packet_id  = id;
      req_header_ref = hdr;
      req_now_time   = now;
      do @(posedge clock); while (busy !== 1'b0);
      apply_fifo_op(op, id, hdr, now);
   endtask

   task automatic idle_cycles(input int n);
      @(negedge clock);
      start = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Stops sending and waits until every owed result has been seen and the
   // block has gone idle, plus a short margin for stray results.
   task automatic settle_queue();
      @(negedge clock);
      start = 1'b0;
      while (owed_answers.size() != 0) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one register through the configuration port, reads it back and
   // updates the shadow settings. Only called while the block is idle.
   task automatic write_register(input logic idx, input logic [CSR_W-1:0] value);
      logic [CSR_W-1:0] readback;
      logic [CSR_W-1:0] mask;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      // Read back in a second transfer without dropping psel.
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      readback = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (idx == REG_MAX_SIZE) begin
         mask = 32'h0000_003F;
         check_field("max_size readback", value & mask, readback & mask);
         size_limit = value[OCC_W-1:0];
      end else begin
         mask = 32'hFFFF_FFFF;
         check_field("max_delay readback", value & mask, readback & mask);
         lifetime = value;
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Every operation on a small queue: empty answers, the full refusal, a
   // remove from the middle, a remove miss and the two undefined codes.
   task automatic test_basic_ops();
      write_register(REG_MAX_SIZE, 32'd3);
      write_register(REG_MAX_DELAY, 32'd100);
      now_stamp = 32'd1000;
      send_item(OP_STATUS, 16'h0000, 32'h0000_0000, now_stamp);
      send_item(OP_DEQUEUE, 16'h0000, 32'h0000_0000, now_stamp);
      send_item(OP_PEEK, 16'h0000, 32'h0000_0000, now_stamp);
      send_item(OP_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF, now_stamp);
      send_item(OP_ENQUEUE, 16'h0000, 32'h0000_0000, now_stamp + 1);
      send_item(OP_ENQUEUE, 16'h1234, 32'hA5A5_5A5A, now_stamp + 2);
      send_item(OP_ENQUEUE, 16'h4321, 32'h0F0F_F0F0, now_stamp + 3);
      send_item(OP_PEEK, 16'h0000, 32'h0000_0000, now_stamp + 4);
      send_item(OP_REMOVE, 16'h0000, 32'h0000_0000, now_stamp + 5);
      send_item(OP_REMOVE, 16'hBEEF, 32'h0000_0000, now_stamp + 6);
      send_item(OP_UNUSED_A, 16'h0000, 32'h0000_0000, now_stamp + 7);
      send_item(OP_UNUSED_B, 16'hFFFF, 32'hFFFF_FFFF, now_stamp + 8);
      send_item(OP_DEQUEUE, 16'h0000, 32'h0000_0000, now_stamp + 9);
      send_item(OP_FLUSH, 16'h0000, 32'h0000_0000, now_stamp + 10);
      settle_queue();
   endtask

   // Status and remove must leave stale entries alone; the next peek sweeps
   // them. Then an entry stamped just before the time wraps must survive a
   // peek after the wrap and expire on a later dequeue.
   task automatic test_expiry();
      write_register(REG_MAX_DELAY, 32'd50);
      now_stamp = 32'd5000;
      send_item(OP_ENQUEUE, 16'h0011, 32'h1111_0000, now_stamp);
      send_item(OP_ENQUEUE, 16'h0022, 32'h2222_0000, now_stamp + 10);
      send_item(OP_STATUS, 16'h0000, 32'h0000_0000, now_stamp + 100);
      send_item(OP_REMOVE, 16'h0099, 32'h0000_0000, now_stamp + 100);
      send_item(OP_PEEK, 16'h0000, 32'h0000_0000, now_stamp + 100);
      send_item(OP_ENQUEUE, 16'h0007, 32'h7777_7777, 32'hFFFF_FFF0);
      send_item(OP_PEEK, 16'h0000, 32'h0000_0000, 32'h0000_0010);
      send_item(OP_DEQUEUE, 16'h0000, 32'h0000_0000, 32'h0000_0030);
      settle_queue();
   endtask

   // With a zero lifetime each sweep clears the whole queue, and a zero size
   // limit refuses every enqueue.
   task automatic test_zero_limits();
      write_register(REG_MAX_DELAY, 32'd0);
      now_stamp = 32'hFFFF_FFFF;
      send_item(OP_ENQUEUE, 16'h0001, 32'h0000_0001, now_stamp);
      send_item(OP_ENQUEUE, 16'h0002, 32'h0000_0002, now_stamp);
      send_item(OP_STATUS, 16'h0000, 32'h0000_0000, now_stamp);
      send_item(OP_PEEK, 16'h0000, 32'h0000_0000, now_stamp);
      settle_queue();
      write_register(REG_MAX_SIZE, 32'd0);
      send_item(OP_ENQUEUE, 16'h0003, 32'h0000_0003, now_stamp);
      settle_queue();
   endtask

   // Random commands under one register setting. Time mostly creeps forward
   // so that entries age and expire in bunches; ids come from a small pool so
   // that removes hit, often on duplicates.
   task automatic run_traffic(input int count, input logic [CSR_W-1:0] size_setting,
                              input logic [CSR_W-1:0] delay_setting,
                              input int idle_pct, input int step_max,
                              input int enqueue_pct);
      logic [OP_W-1:0]  op;
      logic [ID_W-1:0]  id;
      logic [HDR_W-1:0] hdr;
      int               pick;
      write_register(REG_MAX_SIZE, size_setting);
      write_register(REG_MAX_DELAY, delay_setting);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < enqueue_pct) begin
            op = OP_ENQUEUE;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      op = OP_DEQUEUE;
            else if (pick < 50) op = OP_PEEK;
            else if (pick < 75) op = OP_REMOVE;
            else if (pick < 90) op = OP_STATUS;
            else if (pick < 96) op = OP_FLUSH;
            else                op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_B : OP_UNUSED_A;
         end
         id  = ($urandom_range(0, 3) != 0) ? ID_W'($urandom_range(0, 15))
                                           : ID_W'($urandom_range(0, 65535));
         if (op == OP_REMOVE && shadow_entries.size() > 0 && $urandom_range(0, 9) < 6)
            id = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)].id;
         hdr = $urandom;
         pick = $urandom_range(0, 99);
         if (pick == 0)
            now_stamp = $urandom;
         else if (pick < 4)
            now_stamp = now_stamp + $urandom_range(0, step_max * 20);
         else
            now_stamp = now_stamp + $urandom_range(0, step_max);
         send_item(op, id, hdr, now_stamp);
         if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            idle_cycles($urandom_range(1, 6));
         // Now and then the sender waits for the block to drain completely.
         if (i % 50 == 49)
            settle_queue();
      end
      settle_queue();
   endtask

   task automatic test_random_traffic();
      // Deep queue: mostly enqueues with no gaps, so the queue fills to its
      // full depth and refusals follow.
      run_traffic(120, 32'd63, 32'd4000, 0, 30, 80);
      // Short queue and short lifetime with a mostly idle sender.
      run_traffic(110, 32'd6, 32'd250, 68, 60, 45);
      // Time stamps run across the 32-bit wrap.
      now_stamp = 32'hFFFF_FC00;
      run_traffic(110, 32'd12, 32'd150, 9, 30, 50);
      // Longest lifetime: only a full-range age can expire an entry.
      run_traffic(110, 32'd20, 32'hFFFF_FFFF, 68, 1000, 50);
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_op         = OP_STATUS;
      req_packet_id  = '0;
      req_header_ref = '0;
      req_now_time   = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_expiry();
      test_zero_limits();
      test_random_traffic();

      settle_queue();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && owed_answers.size() == 0) begin
         $display("aging_packet_fifo_tb passed");
      end else begin
         $display("aging_packet_fifo_tb failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/apf_pkg.sv
src/apf_ram.sv
src/apf_ctrl.sv
src/aging_packet_fifo.sv
tb/aging_packet_fifo_tb.sv
